FILE: design/sfd_pkg.sv
// Shared types and constants for the SLIP frame deframer.
// No dependencies; imported by the deframer top level.
package sfd_pkg;

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  localparam int         MAX_COPY_W     = 7;
  localparam int         APB_ADDR_W     = 3;
  localparam int         APB_DATA_W     = 32;
  localparam logic       REG_MAX_COPY   = 1'b0;
  localparam logic [6:0] MAX_COPY_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } sfd_state_t;

endpackage

FILE: design/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; used by the deframer top level for the frame store.
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/slip_frame_deframer_top.sv
// SLIP deframer top level: input decoding, frame store control and readout.
// Depends on sfd_pkg and sfd_ram.
//
// Raw bytes are decoded and written into the frame store at one byte per
// cycle while no readout is running. An END byte that closes a non-empty
// frame starts a readout of min(frame length, max_copy_len) bytes, during
// which no input transaction is taken; the store's single read port delivers
// one byte per cycle while the output does not stall. When the copy limit is
// zero, no readout starts. The last result may still wait in the output
// register while the next input transaction is taken. The copy limit sits at
// byte address 0 of the APB port and resets to 64.
module slip_frame_deframer_top
  import sfd_pkg::*;
#(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_data_byte,
  output logic [5:0]            out_byte_index,
  output logic [6:0]            out_frame_length,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_DEPTH);

  sfd_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic                  esc_r, esc_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [MAX_COPY_W-1:0] max_copy_r;
  logic [CNT_W-1:0]      len_r, len_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]     data_idx_r, data_idx_nxt;
  logic                  data_valid_r, data_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r;
  logic [ADDR_W-1:0]     out_idx_r;
  logic [CNT_W-1:0]      out_len_r;
  logic                  out_last_r;

  logic                  in_accept;
  logic                  ram_we;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [7:0]            ram_rdata;
  logic                  load_out;
  logic [MAX_COPY_W-1:0] fill_ext;
  logic [CNT_W-1:0]      copy_cnt;
  logic                  cfg_write;

  sfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign fill_ext = MAX_COPY_W'(fill_r);
  assign copy_cnt = (fill_ext < max_copy_r) ? fill_r : CNT_W'(max_copy_r);

  assign load_out = data_valid_r && (!out_valid_r || !out_stall);
  assign ram_re   = (state_r == ST_DRAIN) && (rd_idx_r != cnt_r) &&
                    (!data_valid_r || load_out);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    esc_nxt        = esc_r;
    in_frame_nxt   = in_frame_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    data_idx_nxt   = data_idx_r;
    ram_we         = 1'b0;
    ram_wdata      = in_rx_byte;
    data_valid_nxt = ram_re || (data_valid_r && !load_out);
    out_valid_nxt  = load_out || (out_valid_r && out_stall);

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_rx_byte == CODE_END) begin
            esc_nxt  = 1'b0;
            fill_nxt = '0;
            if (in_frame_r && (fill_r != '0)) begin
              in_frame_nxt = 1'b0;
              len_nxt      = fill_r;
              cnt_nxt      = copy_cnt;
              rd_idx_nxt   = '0;
              if (copy_cnt != '0) begin
                state_nxt = ST_DRAIN;
              end
            end else begin
              in_frame_nxt = 1'b1;
            end
          end else if (in_frame_r) begin
            if (!esc_r && (in_rx_byte == CODE_ESC)) begin
              esc_nxt = 1'b1;
            end else begin
              esc_nxt = 1'b0;
              if (esc_r && (in_rx_byte == CODE_ESC_END)) begin
                ram_wdata = CODE_END;
              end else if (esc_r && (in_rx_byte == CODE_ESC_ESC)) begin
                ram_wdata = CODE_ESC;
              end
              if (fill_r != FULL_COUNT) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + CNT_W'(1);
              end else begin
                fill_nxt     = '0;
                in_frame_nxt = 1'b0;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (ram_re) begin
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          data_idx_nxt = rd_idx_r[ADDR_W-1:0];
        end
        if ((rd_idx_r == cnt_r) && !data_valid_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      esc_r        <= 1'b0;
      in_frame_r   <= 1'b0;
      data_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_idx_r     <= '0;
      cnt_r        <= '0;
      max_copy_r   <= MAX_COPY_RESET;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      esc_r        <= esc_nxt;
      in_frame_r   <= in_frame_nxt;
      data_valid_r <= data_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_write && (paddr[2] == REG_MAX_COPY)) begin
        max_copy_r <= pwdata[MAX_COPY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    data_idx_r <= data_idx_nxt;
    if (load_out) begin
      out_data_r <= ram_rdata;
      out_idx_r  <= data_idx_r;
      out_len_r  <= len_r;
      out_last_r <= (CNT_W'(data_idx_r) + CNT_W'(1)) == cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_data_r;
  assign out_byte_index   = 6'(out_idx_r);
  assign out_frame_length = 7'(out_len_r);
  assign out_last         = out_last_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_COPY) ? APB_DATA_W'(max_copy_r) : '0;

endmodule
